[design/hpt_pkg.sv]
// Shared constants and types for the homogeneous point transform.
// Fixed-point formats, pipeline widths, matrix reset values and the sideband struct.
// No dependencies.
package hpt_pkg;

    // fixed-point format
    localparam int FRAC_BITS = 16;
    localparam int NUM_DIMS  = 3;
    localparam int NUM_ROWS  = 4;
    localparam int NUM_REGS  = 8;
    localparam int REG_W     = 64;
    localparam int COEF_W    = 32;
    localparam int ADDR_W    = $clog2(NUM_REGS);

    // datapath widths
    localparam int PROD_W    = 2 * COEF_W;
    localparam int RND_W     = PROD_W - FRAC_BITS;
    localparam int SUM_W     = RND_W + 1;
    localparam int MAG_W     = RND_W;
    localparam int DIVD_W    = MAG_W + FRAC_BITS;
    // quotient bits resolved by the divider; anything wider saturates anyway
    localparam int QUOT_BITS = COEF_W + 1;
    localparam int OVF_SH    = QUOT_BITS - FRAC_BITS;

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_BITS - 1);

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(-64'sh0000_0000_8000_0000);
    localparam logic [COEF_W-1:0] OUT_MAX = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0] OUT_MIN = 32'h8000_0000;
    localparam logic [QUOT_BITS:0] QPOS_LIM = (QUOT_BITS + 1)'(32'h7FFF_FFFF);
    localparam logic [QUOT_BITS:0] QNEG_LIM = (QUOT_BITS + 1)'(32'h8000_0000);

    // matrix register reset values (identity)
    localparam logic [REG_W-1:0] MAT_RESET [NUM_REGS] = '{
        64'h0000_0000_0001_0000, 64'h0,
        64'h0001_0000_0000_0000, 64'h0,
        64'h0,                   64'h0000_0000_0001_0000,
        64'h0,                   64'h0001_0000_0000_0000
    };

    // per-item control carried alongside the divider
    typedef struct packed {
        logic                               point;
        logic                               wzero;
        logic [NUM_DIMS-1:0]                neg;
        logic [NUM_DIMS-1:0][COEF_W-1:0]    dval;
        logic                               dsat;
    } t_side;

endpackage

[design/hpt_divider.sv]
// Pipelined restoring divider: (num << FRAC_BITS) / den, one quotient bit per stage.
// Flags quotients of 2^QUOT_BITS or more as overflow. Depends on hpt_pkg.
module hpt_divider (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [hpt_pkg::MAG_W-1:0]          i_num,
    input  logic [hpt_pkg::MAG_W-1:0]          i_den,
    output logic [hpt_pkg::QUOT_BITS-1:0]      o_quot,
    output logic [hpt_pkg::MAG_W-1:0]          o_rem,
    output logic [hpt_pkg::MAG_W-1:0]          o_den,
    output logic                               o_ovf
);

    logic [hpt_pkg::MAG_W-1:0]     r_rem [hpt_pkg::QUOT_BITS];
    logic [hpt_pkg::MAG_W-1:0]     r_den [hpt_pkg::QUOT_BITS];
    logic [hpt_pkg::QUOT_BITS-1:0] r_low [hpt_pkg::QUOT_BITS];
    logic [hpt_pkg::QUOT_BITS-1:0] r_q   [hpt_pkg::QUOT_BITS];
    logic                          r_ovf [hpt_pkg::QUOT_BITS];

    // dividend with the fraction shift applied
    logic [hpt_pkg::DIVD_W-1:0] dividend;
    assign dividend = {i_num, hpt_pkg::FRAC_BITS'(0)};

    for (genvar k = 0; k < hpt_pkg::QUOT_BITS; k++) begin : g_stage
        logic [hpt_pkg::MAG_W-1:0]     rem_in;
        logic [hpt_pkg::MAG_W-1:0]     den_in;
        logic [hpt_pkg::QUOT_BITS-1:0] low_in;
        logic [hpt_pkg::QUOT_BITS-1:0] q_in;
        logic                          ovf_in;
        logic [hpt_pkg::MAG_W:0]       trial;
        logic [hpt_pkg::MAG_W:0]       diff;
        logic                          take;

        if (k == 0) begin : g_first
            // top bits form the starting remainder; quotient beyond range flags overflow
            assign rem_in = hpt_pkg::MAG_W'(dividend[hpt_pkg::DIVD_W-1:hpt_pkg::QUOT_BITS]);
            assign low_in = dividend[hpt_pkg::QUOT_BITS-1:0];
            assign q_in   = '0;
            assign den_in = i_den;
            assign ovf_in = {hpt_pkg::OVF_SH'(0), i_num} >= {i_den, hpt_pkg::OVF_SH'(0)};
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign low_in = r_low[k-1];
            assign q_in   = r_q[k-1];
            assign den_in = r_den[k-1];
            assign ovf_in = r_ovf[k-1];
        end

        // one restoring step
        assign trial = {rem_in, low_in[hpt_pkg::QUOT_BITS-1]};
        assign diff  = trial - {1'b0, den_in};
        assign take  = trial >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= take ? diff[hpt_pkg::MAG_W-1:0] : trial[hpt_pkg::MAG_W-1:0];
                r_low[k] <= {low_in[hpt_pkg::QUOT_BITS-2:0], 1'b0};
                r_q[k]   <= {q_in[hpt_pkg::QUOT_BITS-2:0], take};
                r_den[k] <= den_in;
                r_ovf[k] <= ovf_in;
            end
        end
    end

    assign o_quot = r_q[hpt_pkg::QUOT_BITS-1];
    assign o_rem  = r_rem[hpt_pkg::QUOT_BITS-1];
    assign o_den  = r_den[hpt_pkg::QUOT_BITS-1];
    assign o_ovf  = r_ovf[hpt_pkg::QUOT_BITS-1];

endmodule

[design/homogeneous_point_transform.sv]
// Top level of the homogeneous point transform: matrix registers, multiply/round/sum
// stages, three hpt_divider lanes and the saturating output stage. Depends on hpt_pkg.
//
// Each transaction carries one point (tuser = 0) or direction (tuser = 1) and yields
// one result: multiply, round, sum and magnitude stages, the bit-per-stage divider
// lanes, then rounding and saturation. A new transaction is accepted every cycle;
// the whole pipeline advances together and holds only while a result sits in the
// output register unaccepted. The matrix must be written by the user through the
// config port only while no transaction is in flight; the block does not enforce it.
module homogeneous_point_transform (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config port
    input  logic                          i_cfg_we,
    input  logic [hpt_pkg::ADDR_W-1:0]    i_cfg_addr,
    input  logic [hpt_pkg::REG_W-1:0]     i_cfg_wdata,
    // input stream
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [95:0]                   i_s_axis_tdata,  // in_x, in_y, in_z
    input  logic                          i_s_axis_tuser,  // action
    // output stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [95:0]                   o_m_axis_tdata,  // out_x, out_y, out_z
    output logic [1:0]                    o_m_axis_tuser   // w_was_zero, saturated
);

    localparam int QB = hpt_pkg::QUOT_BITS;

    logic adv;

    // matrix registers
    logic [hpt_pkg::REG_W-1:0] r_mat [hpt_pkg::NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat <= hpt_pkg::MAT_RESET;
        end else if (i_cfg_we) begin
            r_mat[i_cfg_addr] <= i_cfg_wdata;
        end
    end

    // coefficient view of the registers
    logic signed [hpt_pkg::COEF_W-1:0] coef [hpt_pkg::NUM_ROWS][hpt_pkg::NUM_ROWS];

    always_comb begin
        for (int r = 0; r < hpt_pkg::NUM_ROWS; r++) begin
            for (int c = 0; c < hpt_pkg::NUM_ROWS; c++) begin
                coef[r][c] = c[0] ? r_mat[r*2 + (c >> 1)][63:32]
                                  : r_mat[r*2 + (c >> 1)][31:0];
            end
        end
    end

    // stage 1: products
    logic                              r1_vld, r1_point;
    logic signed [hpt_pkg::PROD_W-1:0] r1_prod [hpt_pkg::NUM_ROWS][hpt_pkg::NUM_DIMS];
    logic signed [hpt_pkg::COEF_W-1:0] coord [hpt_pkg::NUM_DIMS];

    always_comb begin
        for (int k = 0; k < hpt_pkg::NUM_DIMS; k++) begin
            coord[k] = i_s_axis_tdata[k*hpt_pkg::COEF_W +: hpt_pkg::COEF_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_point <= ~i_s_axis_tuser;
            for (int r = 0; r < hpt_pkg::NUM_ROWS; r++) begin
                for (int c = 0; c < hpt_pkg::NUM_DIMS; c++) begin
                    r1_prod[r][c] <= coef[r][c] * coord[c];
                end
            end
        end
    end

    // stage 2: round products to the fixed-point grid
    logic                              r2_vld, r2_point;
    logic signed [hpt_pkg::RND_W-1:0]  r2_rnd [hpt_pkg::NUM_ROWS][hpt_pkg::NUM_DIMS];
    logic signed [hpt_pkg::PROD_W-1:0] biased [hpt_pkg::NUM_ROWS][hpt_pkg::NUM_DIMS];

    always_comb begin
        for (int r = 0; r < hpt_pkg::NUM_ROWS; r++) begin
            for (int c = 0; c < hpt_pkg::NUM_DIMS; c++) begin
                biased[r][c] = r1_prod[r][c] + hpt_pkg::ROUND_HALF;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_point <= r1_point;
            for (int r = 0; r < hpt_pkg::NUM_ROWS; r++) begin
                for (int c = 0; c < hpt_pkg::NUM_DIMS; c++) begin
                    r2_rnd[r][c] <= biased[r][c][hpt_pkg::PROD_W-1:hpt_pkg::FRAC_BITS];
                end
            end
        end
    end

    // stage 3: row sums plus translation in point mode
    logic                              r3_vld, r3_point;
    logic signed [hpt_pkg::SUM_W-1:0]  r3_sum [hpt_pkg::NUM_ROWS];
    logic signed [hpt_pkg::SUM_W-1:0]  trans  [hpt_pkg::NUM_ROWS];

    always_comb begin
        for (int r = 0; r < hpt_pkg::NUM_ROWS; r++) begin
            trans[r] = r2_point ? hpt_pkg::SUM_W'(coef[r][hpt_pkg::NUM_DIMS]) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_point <= r2_point;
            for (int r = 0; r < hpt_pkg::NUM_ROWS; r++) begin
                r3_sum[r] <= hpt_pkg::SUM_W'(r2_rnd[r][0]) + hpt_pkg::SUM_W'(r2_rnd[r][1])
                           + hpt_pkg::SUM_W'(r2_rnd[r][2]) + trans[r];
            end
        end
    end

    // stage 4: magnitudes, signs, w check and the direction-mode results
    logic                              r4_vld;
    hpt_pkg::t_side                    r4_side, side4;
    logic [hpt_pkg::MAG_W-1:0]         r4_num [hpt_pkg::NUM_DIMS];
    logic [hpt_pkg::MAG_W-1:0]         r4_den;
    logic [hpt_pkg::MAG_W-1:0]         mag [hpt_pkg::NUM_ROWS];
    logic signed [hpt_pkg::SUM_W-1:0]  neg_sum [hpt_pkg::NUM_ROWS];

    always_comb begin
        side4       = '0;
        side4.point = r3_point;
        side4.wzero = r3_point && (r3_sum[3] == '0);
        for (int r = 0; r < hpt_pkg::NUM_ROWS; r++) begin
            neg_sum[r] = -r3_sum[r];
            mag[r] = r3_sum[r][hpt_pkg::SUM_W-1] ? neg_sum[r][hpt_pkg::MAG_W-1:0]
                                                 : r3_sum[r][hpt_pkg::MAG_W-1:0];
        end
        for (int k = 0; k < hpt_pkg::NUM_DIMS; k++) begin
            side4.neg[k] = r3_sum[k][hpt_pkg::SUM_W-1] ^ r3_sum[3][hpt_pkg::SUM_W-1];
            if (r3_sum[k] > hpt_pkg::SUM_MAX) begin
                side4.dval[k] = hpt_pkg::OUT_MAX;
                side4.dsat    = 1'b1;
            end else if (r3_sum[k] < hpt_pkg::SUM_MIN) begin
                side4.dval[k] = hpt_pkg::OUT_MIN;
                side4.dsat    = 1'b1;
            end else begin
                side4.dval[k] = r3_sum[k][hpt_pkg::COEF_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_side <= side4;
            r4_den  <= mag[3];
            for (int k = 0; k < hpt_pkg::NUM_DIMS; k++) begin
                r4_num[k] <= mag[k];
            end
        end
    end

    // divider lanes, with control carried alongside
    logic [QB-1:0]             div_quot [hpt_pkg::NUM_DIMS];
    logic [hpt_pkg::MAG_W-1:0] div_rem  [hpt_pkg::NUM_DIMS];
    logic [hpt_pkg::MAG_W-1:0] div_den  [hpt_pkg::NUM_DIMS];
    logic                      div_ovf  [hpt_pkg::NUM_DIMS];

    for (genvar k = 0; k < hpt_pkg::NUM_DIMS; k++) begin : g_lane
        hpt_divider u_div (
            .i_clk  (i_clk),
            .i_en   (adv),
            .i_num  (r4_num[k]),
            .i_den  (r4_den),
            .o_quot (div_quot[k]),
            .o_rem  (div_rem[k]),
            .o_den  (div_den[k]),
            .o_ovf  (div_ovf[k])
        );
    end

    hpt_pkg::t_side r_side [QB];
    logic           r_vline [QB];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side[0] <= r4_side;
            for (int s = 1; s < QB; s++) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    // stage E: round quotient half away from zero
    logic                   r5_vld;
    hpt_pkg::t_side         r5_side;
    logic [QB:0]            r5_q   [hpt_pkg::NUM_DIMS];
    logic                   r5_ovf [hpt_pkg::NUM_DIMS];
    logic                   rnd_up [hpt_pkg::NUM_DIMS];

    always_comb begin
        for (int k = 0; k < hpt_pkg::NUM_DIMS; k++) begin
            rnd_up[k] = {div_rem[k], 1'b0} >= {1'b0, div_den[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_side <= r_side[QB-1];
            for (int k = 0; k < hpt_pkg::NUM_DIMS; k++) begin
                r5_q[k]   <= {1'b0, div_quot[k]} + (QB + 1)'(rnd_up[k]);
                r5_ovf[k] <= div_ovf[k];
            end
        end
    end

    // stage F: sign, saturation and mode select into the output register
    logic                      r_out_vld;
    logic [95:0]               r_out_data;
    logic                      r_out_wzero, r_out_sat;
    logic [95:0]               n_out_data;
    logic                      n_out_sat;
    logic [hpt_pkg::NUM_DIMS-1:0] qsat;
    logic [hpt_pkg::COEF_W-1:0]   qval [hpt_pkg::NUM_DIMS];

    always_comb begin
        for (int k = 0; k < hpt_pkg::NUM_DIMS; k++) begin
            if (r5_side.neg[k]) begin
                qsat[k] = r5_ovf[k] || (r5_q[k] > hpt_pkg::QNEG_LIM);
                qval[k] = qsat[k] ? hpt_pkg::OUT_MIN : -r5_q[k][hpt_pkg::COEF_W-1:0];
            end else begin
                qsat[k] = r5_ovf[k] || (r5_q[k] > hpt_pkg::QPOS_LIM);
                qval[k] = qsat[k] ? hpt_pkg::OUT_MAX : r5_q[k][hpt_pkg::COEF_W-1:0];
            end
        end
        for (int k = 0; k < hpt_pkg::NUM_DIMS; k++) begin
            if (!r5_side.point) begin
                n_out_data[k*hpt_pkg::COEF_W +: hpt_pkg::COEF_W] = r5_side.dval[k];
            end else if (r5_side.wzero) begin
                n_out_data[k*hpt_pkg::COEF_W +: hpt_pkg::COEF_W] = '0;
            end else begin
                n_out_data[k*hpt_pkg::COEF_W +: hpt_pkg::COEF_W] = qval[k];
            end
        end
        if (!r5_side.point) begin
            n_out_sat = r5_side.dsat;
        end else begin
            n_out_sat = !r5_side.wzero && (|qsat);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data  <= n_out_data;
            r_out_wzero <= r5_side.wzero;
            r_out_sat   <= n_out_sat;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r5_vld    <= 1'b0;
            r_out_vld <= 1'b0;
            for (int s = 0; s < QB; s++) begin
                r_vline[s] <= 1'b0;
            end
        end else if (adv) begin
            r1_vld     <= i_s_axis_tvalid;
            r2_vld     <= r1_vld;
            r3_vld     <= r2_vld;
            r4_vld     <= r3_vld;
            r_vline[0] <= r4_vld;
            for (int s = 1; s < QB; s++) begin
                r_vline[s] <= r_vline[s-1];
            end
            r5_vld     <= r_vline[QB-1];
            r_out_vld  <= r5_vld;
        end
    end

    assign adv             = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = adv;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = {r_out_sat, r_out_wzero};

`ifndef ASSERT_OFF
    // the pipeline only holds behind a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled without a blocked result");

    // zero w forces zero coordinates and no saturation
    a_wzero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0 && !o_m_axis_tuser[1]))
        else $error("w_was_zero result carries data");

    // divider remainder stays below the divisor when in range
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vline[QB-1] && !div_ovf[0] && div_den[0] != '0) |-> (div_rem[0] < div_den[0]))
        else $error("divider remainder out of range");

    // an accepted transaction enters stage one
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r1_vld)
        else $error("accepted transaction lost at entry");
`endif

endmodule
